### sv/bfpa_pkg.sv
// Shared constants, types and helpers for the best-fit partition allocator.
package bfpa_pkg;

    localparam int MAX_PARTS   = 32;
    // Must be a power of two: rounding uses a mask.
    localparam int ALIGN_BYTES = 4;
    localparam int IDX_W       = $clog2(MAX_PARTS);
    localparam int CNT_W       = $clog2(MAX_PARTS + 1);
    localparam int DATA_W      = 16;
    localparam int NEED_W      = DATA_W + 1;
    localparam int CNTO_W      = 6;
    localparam logic [DATA_W-1:0] HEAP_RESET = 16'd4096;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_FIT      = 2'd1,
        ST_TABLE_FULL  = 2'd2,
        ST_UNKNOWN_OFF = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WB_MAIN,
        S_WB_BEST,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic wb_main;
        logic wb_best;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic split;
        logic out_free;
    } t_dp_sts;

    // Round up to the alignment; zero becomes one alignment unit.
    function automatic logic [NEED_W-1:0] round_size(input logic [DATA_W-1:0] req);
        logic [NEED_W-1:0] sum;
        sum = {1'b0, req} + NEED_W'(ALIGN_BYTES - 1);
        if (req == '0) begin
            return NEED_W'(ALIGN_BYTES);
        end
        return sum & ~NEED_W'(ALIGN_BYTES - 1);
    endfunction

endpackage

### sv/bfpa_if.sv
// Request and response channel interfaces of the allocator.
interface bfpa_cmd_if import bfpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [DATA_W-1:0] req_size;
    logic [DATA_W-1:0] free_offset;

    modport source(output valid, op, req_size, free_offset, input ready);
    modport sink(input valid, op, req_size, free_offset, output ready);
endinterface

interface bfpa_rsp_if import bfpa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [DATA_W-1:0] alloc_offset;
    logic [DATA_W-1:0] granted_size;
    logic [CNTO_W-1:0] occupied_count;
    logic [DATA_W-1:0] occupied_bytes;
    logic [CNTO_W-1:0] hole_count;
    logic [DATA_W-1:0] hole_bytes;

    modport source(output valid, status, alloc_offset, granted_size, occupied_count,
                   occupied_bytes, hole_count, hole_bytes, input ready);
    modport sink(input valid, status, alloc_offset, granted_size, occupied_count,
                 occupied_bytes, hole_count, hole_bytes, output ready);
endinterface

### sv/bfpa_ctrl.sv
// Sequencer: scan, write-back and result hand-off for one item at a time.
module bfpa_ctrl import bfpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_WB_MAIN;
            end
            S_WB_MAIN: begin
                n_state = i_sts.split ? S_WB_BEST : S_OUT;
            end
            S_WB_BEST: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_WB_MAIN: begin
                o_cmd.wb_main = 1'b1;
            end
            S_WB_BEST: begin
                o_cmd.wb_best = 1'b1;
            end
            S_OUT: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### sv/bfpa_dp.sv
// Datapath: partition table, best-fit / offset scan, counters and result register.
module bfpa_dp import bfpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DATA_W-1:0] i_cfg_data,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_op,
    input  logic [DATA_W-1:0] i_req_size,
    input  logic [DATA_W-1:0] i_free_offset,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_status,
    output logic [DATA_W-1:0] o_alloc_offset,
    output logic [DATA_W-1:0] o_granted_size,
    output logic [CNTO_W-1:0] o_occupied_count,
    output logic [DATA_W-1:0] o_occupied_bytes,
    output logic [CNTO_W-1:0] o_hole_count,
    output logic [DATA_W-1:0] o_hole_bytes
);

    // Table storage: offset and size per entry, one read port driven by the scan.
    logic [DATA_W-1:0] mem_off  [MAX_PARTS];
    logic [DATA_W-1:0] mem_size [MAX_PARTS];

    logic [MAX_PARTS-1:0] r_valid;
    logic [MAX_PARTS-1:0] r_taken;

    // Captured item
    t_op               r_op;
    logic [NEED_W-1:0] r_need;
    logic [DATA_W-1:0] r_foff;

    // Scan pipeline
    logic [CNT_W-1:0]  r_cnt;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    logic [DATA_W-1:0] r_rd_off;
    logic [DATA_W-1:0] r_rd_size;

    // Selected entry (best fit or offset hit) and first spare entry
    logic              r_sel_fnd;
    logic [IDX_W-1:0]  r_sel_idx;
    logic [DATA_W-1:0] r_sel_off;
    logic [DATA_W-1:0] r_sel_size;
    logic              r_sel_taken;
    logic              r_spare_fnd;
    logic [IDX_W-1:0]  r_spare_idx;

    // Running totals
    logic [CNT_W-1:0]  r_occ_n;
    logic [CNT_W-1:0]  r_hole_n;
    logic [DATA_W-1:0] r_occ_b;
    logic [DATA_W-1:0] r_hole_b;

    // Result of the write-back
    t_status           r_res_status;
    logic [DATA_W-1:0] r_res_off;
    logic [DATA_W-1:0] r_res_gsize;

    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_off;
    logic [DATA_W-1:0] r_out_gsize;
    logic [CNT_W-1:0]  r_out_occ_n;
    logic [DATA_W-1:0] r_out_occ_b;
    logic [CNT_W-1:0]  r_out_hole_n;
    logic [DATA_W-1:0] r_out_hole_b;

    logic              init;
    logic [DATA_W-1:0] init_size;
    logic              cur_valid;
    logic              cur_taken;
    logic              fit;
    logic              better;
    logic              hit;
    logic              take;
    logic              spare_take;
    logic [DATA_W-1:0] need16;
    logic              bigger;
    logic              split;

    assign init      = !i_rst_n || i_cfg_we;
    assign init_size = !i_rst_n ? HEAP_RESET : i_cfg_data;
    assign need16    = r_need[DATA_W-1:0];

    assign cur_valid = r_valid[r_cmp_idx];
    assign cur_taken = r_taken[r_cmp_idx];
    assign fit       = cur_valid && !cur_taken && ({1'b0, r_rd_size} >= r_need);
    assign better    = !r_sel_fnd || (r_rd_size < r_sel_size) ||
                       ((r_rd_size == r_sel_size) && (r_rd_off < r_sel_off));
    assign hit       = cur_valid && (r_rd_off == r_foff) && !r_sel_fnd;
    assign take      = r_cmp_vld && ((r_op == OP_ALLOC) ? (fit && better) : hit);
    assign spare_take = r_cmp_vld && !cur_valid && !r_spare_fnd;

    assign bigger = r_sel_size > need16;
    assign split  = (r_op == OP_ALLOC) && r_sel_fnd && bigger && r_spare_fnd;

    assign o_sts.scan_done = (r_cnt == CNT_W'(MAX_PARTS));
    assign o_sts.split     = split;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Table write port: init, split remainder, then trimmed best entry
    always_ff @(posedge i_clk) begin
        if (init) begin
            mem_off[0]  <= '0;
            mem_size[0] <= init_size;
        end else if (i_cmd.wb_main && split) begin
            mem_off[r_spare_idx]  <= r_sel_off + need16;
            mem_size[r_spare_idx] <= r_sel_size - need16;
        end else if (i_cmd.wb_best) begin
            mem_size[r_sel_idx] <= need16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_rd_off  <= mem_off[r_cnt[IDX_W-1:0]];
            r_rd_size <= mem_size[r_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= t_op'(i_op);
            r_need <= round_size(i_req_size);
            r_foff <= i_free_offset;
        end
    end

    // Scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_cmp_vld   <= 1'b0;
            r_sel_fnd   <= 1'b0;
            r_spare_fnd <= 1'b0;
        end else if (i_cmd.start) begin
            r_cnt       <= '0;
            r_cmp_vld   <= 1'b0;
            r_sel_fnd   <= 1'b0;
            r_spare_fnd <= 1'b0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= (r_cnt < CNT_W'(MAX_PARTS));
            r_cmp_idx <= r_cnt[IDX_W-1:0];
            if (r_cnt < CNT_W'(MAX_PARTS)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (take) begin
                r_sel_fnd   <= 1'b1;
                r_sel_idx   <= r_cmp_idx;
                r_sel_off   <= r_rd_off;
                r_sel_size  <= r_rd_size;
                r_sel_taken <= cur_taken;
            end
            if (spare_take) begin
                r_spare_fnd <= 1'b1;
                r_spare_idx <= r_cmp_idx;
            end
        end
    end

    // Entry flags, totals and result
    always_ff @(posedge i_clk) begin
        if (init) begin
            r_valid  <= {{(MAX_PARTS-1){1'b0}}, 1'b1};
            r_taken  <= '0;
            r_occ_n  <= '0;
            r_occ_b  <= '0;
            r_hole_n <= CNT_W'(1);
            r_hole_b <= init_size;
        end else if (i_cmd.wb_main) begin
            r_res_off   <= '0;
            r_res_gsize <= '0;
            if (r_op == OP_ALLOC) begin
                if (!r_sel_fnd) begin
                    r_res_status <= ST_NO_FIT;
                end else if (bigger && !r_spare_fnd) begin
                    r_res_status <= ST_TABLE_FULL;
                end else begin
                    r_res_status         <= ST_OK;
                    r_res_off            <= r_sel_off;
                    r_res_gsize          <= need16;
                    r_taken[r_sel_idx]   <= 1'b1;
                    r_occ_n              <= r_occ_n + 1'b1;
                    r_occ_b              <= r_occ_b + need16;
                    r_hole_b             <= r_hole_b - need16;
                    if (bigger) begin
                        r_valid[r_spare_idx] <= 1'b1;
                        r_taken[r_spare_idx] <= 1'b0;
                    end else begin
                        r_hole_n <= r_hole_n - 1'b1;
                    end
                end
            end else begin
                if (!r_sel_fnd) begin
                    r_res_status <= ST_UNKNOWN_OFF;
                end else begin
                    r_res_status       <= ST_OK;
                    r_taken[r_sel_idx] <= 1'b0;
                    // Freeing a free partition changes no totals
                    if (r_sel_taken) begin
                        r_occ_n  <= r_occ_n - 1'b1;
                        r_occ_b  <= r_occ_b - r_sel_size;
                        r_hole_n <= r_hole_n + 1'b1;
                        r_hole_b <= r_hole_b + r_sel_size;
                    end
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_off    <= r_res_off;
            r_out_gsize  <= r_res_gsize;
            r_out_occ_n  <= r_occ_n;
            r_out_occ_b  <= r_occ_b;
            r_out_hole_n <= r_hole_n;
            r_out_hole_b <= r_hole_b;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_alloc_offset   = r_out_off;
    assign o_granted_size   = r_out_gsize;
    assign o_occupied_count = CNTO_W'(r_out_occ_n);
    assign o_occupied_bytes = r_out_occ_b;
    assign o_hole_count     = CNTO_W'(r_out_hole_n);
    assign o_hole_bytes     = r_out_hole_b;

endmodule

### sv/best_fit_partition_allocator.sv
// Best-fit heap partition allocator: top level.
//
// Requests arrive on i_cmd (valid/ready): op selects allocate or free,
// req_size is the allocate size, free_offset the partition to free.
// Each item yields one response on o_rsp (valid/ready) with a status,
// the granted offset and size, and occupied / free partition counts and bytes.
// i_cfg_we with i_cfg_data writes the heap size and rebuilds the table as one
// free partition; write it only while no item is in flight.
// One item is handled at a time. After acceptance the 32-entry table is
// scanned through its single read port, followed by the main write-back,
// a second write-back of the trimmed best entry when a remainder is split
// off, and the load of the output register; a new item is accepted only
// after the previous response has been loaded.
// A finished response sits in the output register; the next item is accepted
// and scanned while it waits, and only its own hand-off stalls on o_rsp.ready.
// Synchronous reset sets the heap to 4096 bytes in one free partition, clears
// the occupied count and bytes and drops any pending response.
module best_fit_partition_allocator import bfpa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DATA_W-1:0] i_cfg_data,
    bfpa_cmd_if.sink          i_cmd,
    bfpa_rsp_if.source        o_rsp
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    bfpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    bfpa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_op             (i_cmd.op),
        .i_req_size       (i_cmd.req_size),
        .i_free_offset    (i_cmd.free_offset),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_status         (o_rsp.status),
        .o_alloc_offset   (o_rsp.alloc_offset),
        .o_granted_size   (o_rsp.granted_size),
        .o_occupied_count (o_rsp.occupied_count),
        .o_occupied_bytes (o_rsp.occupied_bytes),
        .o_hole_count     (o_rsp.hole_count),
        .o_hole_bytes     (o_rsp.hole_bytes)
    );

    // One item at a time: no acceptance in the cycle after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("item accepted while another is in flight");

    // Partitions in use never exceed the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |->
            (({1'b0, o_rsp.occupied_count} + {1'b0, o_rsp.hole_count}) <=
             7'(MAX_PARTS)))
        else $error("partition count exceeds table depth");

    // A non-zero granted size is a multiple of the alignment
    a_granted_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_OK) && (o_rsp.granted_size != '0)) |->
            ((o_rsp.granted_size & DATA_W'(ALIGN_BYTES - 1)) == '0))
        else $error("granted size not aligned");

    // A failed item reports neither an offset nor a size
    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |->
            ((o_rsp.granted_size == '0) && (o_rsp.alloc_offset == '0)))
        else $error("failed item reports a grant");

endmodule
